FILE: sv/assert_macros.svh
// Assertion macros used by the asserting RTL file, the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/mtrr_pkg.sv
// Shared types and constants for the memory type range resolver.
`timescale 1ns / 1ps
package mtrr_pkg;

    localparam int MAX_RANGES_DEF = 16;

    localparam int FRAME_W = 40;
    localparam int ADDR_W  = 52;
    localparam int TYPE_W  = 3;
    localparam int PAGE_W  = 18;
    localparam int FRAME_SHIFT      = 12;
    localparam int LARGE_PAGE_SHIFT = 21;

    localparam logic [TYPE_W-1:0] TYPE_UC = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_WB = 3'd6;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_STORE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic span_calc;
        logic store;
        logic walk_first;
        logic walk_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic load_ok;
        logic table_full;
        logic count_zero;
        logic page_zero;
        logic walk_done;
        logic out_busy;
    } sts_t;

endpackage

FILE: sv/mtrr_ctrl.sv
// Controller state machine for the memory type range resolver.
`timescale 1ns / 1ps
module mtrr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mtrr_pkg::sts_t sts,
    output mtrr_pkg::cmd_t cmd
);
    import mtrr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.is_query)
                begin
                    if (sts.count_zero || sts.page_zero)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.walk_first = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
                else if (sts.load_ok && !sts.table_full)
                begin
                    cmd.span_calc = 1'b1;
                    state_next    = ST_STORE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mtrr_dp.sv
// Datapath: item capture, range table, range walk and result register.
`timescale 1ns / 1ps
module mtrr_dp #(
    parameter int MAX_RANGES = mtrr_pkg::MAX_RANGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mtrr_pkg::cmd_t                  cmd,
    output mtrr_pkg::sts_t                  sts,
    input  logic                            func,
    input  logic [mtrr_pkg::FRAME_W-1:0]    base_frame,
    input  logic [mtrr_pkg::FRAME_W-1:0]    mask_frame,
    input  logic [mtrr_pkg::TYPE_W-1:0]     range_type,
    input  logic                            range_enable,
    input  logic [mtrr_pkg::PAGE_W-1:0]     page_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mtrr_pkg::TYPE_W-1:0]     memory_type,
    output logic                            accepted
);
    import mtrr_pkg::*;

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int PAD_W = ADDR_W - PAGE_W - LARGE_PAGE_SHIFT;

    // range table
    logic [ADDR_W-1:0] lo_mem [MAX_RANGES];
    logic [ADDR_W-1:0] hi_mem [MAX_RANGES];
    logic [TYPE_W-1:0] ty_mem [MAX_RANGES];

    logic              func_reg;
    logic [FRAME_W-1:0] base_reg;
    logic [FRAME_W-1:0] mask_reg;
    logic [TYPE_W-1:0] type_reg;
    logic              en_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [FRAME_W-1:0] span_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  walk_idx_reg;

    logic [ADDR_W-1:0] lo_rd_reg;
    logic [ADDR_W-1:0] hi_rd_reg;
    logic [TYPE_W-1:0] ty_rd_reg;

    logic [TYPE_W-1:0] res_type_reg;
    logic [TYPE_W-1:0] res_type_next;
    logic              res_acc_reg;
    logic              res_acc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TYPE_W-1:0] out_type_reg;
    logic              out_acc_reg;

    logic [FRAME_W-1:0] mask_m1;
    logic [FRAME_W:0]   hi_sum;
    logic [FRAME_W-1:0] hi_frame;
    logic [ADDR_W-1:0]  page_first;
    logic [ADDR_W-1:0]  page_last;
    logic               hit;

    assign mask_m1  = mask_reg - FRAME_W'(1);
    assign hi_sum   = {1'b0, base_reg} + {1'b0, span_reg};
    assign hi_frame = hi_sum[FRAME_W] ? {FRAME_W{1'b1}} : hi_sum[FRAME_W-1:0];

    assign page_first = {{PAD_W{1'b0}}, page_reg, {LARGE_PAGE_SHIFT{1'b0}}};
    assign page_last  = {{PAD_W{1'b0}}, page_reg, {LARGE_PAGE_SHIFT{1'b1}}};
    assign hit        = (page_first <= hi_rd_reg) && (page_last >= lo_rd_reg);

    always_comb
    begin
        sts            = '0;
        sts.is_query   = (func_reg == FUNC_QUERY);
        sts.load_ok    = en_reg && (type_reg != TYPE_WB) && (mask_reg != '0);
        sts.table_full = (count_reg >= CNT_W'(MAX_RANGES));
        sts.count_zero = (count_reg == '0);
        sts.page_zero  = (page_reg == '0);
        sts.walk_done  = (hit && (ty_rd_reg == TYPE_UC)) || (walk_idx_reg == count_reg);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            base_reg <= base_frame;
            mask_reg <= mask_frame;
            type_reg <= range_type;
            en_reg   <= range_enable;
            page_reg <= page_index;
        end
        if (cmd.span_calc)
        begin
            span_reg <= (mask_reg ^ mask_m1) >> 1;
        end
        if (cmd.store)
        begin
            lo_mem[count_reg[IDX_W-1:0]] <= {base_reg, {FRAME_SHIFT{1'b0}}};
            hi_mem[count_reg[IDX_W-1:0]] <= {hi_frame, {FRAME_SHIFT{1'b1}}};
            ty_mem[count_reg[IDX_W-1:0]] <= type_reg;
        end
        if (cmd.walk_first)
        begin
            lo_rd_reg <= lo_mem[0];
            hi_rd_reg <= hi_mem[0];
            ty_rd_reg <= ty_mem[0];
        end
        else if (cmd.walk_step && !sts.walk_done)
        begin
            lo_rd_reg <= lo_mem[walk_idx_reg[IDX_W-1:0]];
            hi_rd_reg <= hi_mem[walk_idx_reg[IDX_W-1:0]];
            ty_rd_reg <= ty_mem[walk_idx_reg[IDX_W-1:0]];
        end
        if (cmd.walk_first)
        begin
            walk_idx_reg <= CNT_W'(1);
        end
        else if (cmd.walk_step)
        begin
            walk_idx_reg <= walk_idx_reg + CNT_W'(1);
        end
        res_type_reg <= res_type_next;
        res_acc_reg  <= res_acc_next;
        if (cmd.out_load)
        begin
            out_type_reg <= res_type_reg;
            out_acc_reg  <= res_acc_reg;
        end
    end

    always_comb
    begin
        res_type_next = res_type_reg;
        res_acc_next  = res_acc_reg;
        if (cmd.capture)
        begin
            res_acc_next = 1'b0;
            if (func != FUNC_QUERY)
            begin
                res_type_next = TYPE_UC;
            end
            else if (count_reg != '0 && page_index == '0)
            begin
                res_type_next = TYPE_UC;
            end
            else
            begin
                res_type_next = TYPE_WB;
            end
        end
        else if (cmd.store)
        begin
            res_acc_next = 1'b1;
        end
        else if (cmd.walk_step && hit)
        begin
            res_type_next = ty_rd_reg;
        end
    end

    always_comb
    begin
        count_next     = cmd.store ? count_reg + CNT_W'(1) : count_reg;
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign memory_type = out_type_reg;
    assign accepted    = out_acc_reg;

endmodule

FILE: sv/mtrr_memory_type_resolver_unit.sv
// Top level of the memory type range resolver.
//
//   channel   direction   handshake              payload
//   in        sink        in_valid / in_ready    func, base_frame, mask_frame,
//                                                range_type, range_enable, page_index
//   out       source      out_valid / out_ready  memory_type, accepted
//
// One item at a time: a skipped load or a query on an empty table or page 0 goes from
// decode straight to done, a stored load passes the store state, and other queries walk
// the ranges one per cycle, up to all stored ranges, fewer when an uncacheable hit ends it.
// Reset clears the range count and the output valid; table contents are kept.
// A new item is taken while the previous result waits on out_ready; it then stalls in
// its last cycle until the output register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mtrr_memory_type_resolver_unit #(
    parameter int MAX_RANGES = mtrr_pkg::MAX_RANGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [mtrr_pkg::FRAME_W-1:0]    base_frame,
    input  logic [mtrr_pkg::FRAME_W-1:0]    mask_frame,
    input  logic [mtrr_pkg::TYPE_W-1:0]     range_type,
    input  logic                            range_enable,
    input  logic [mtrr_pkg::PAGE_W-1:0]     page_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mtrr_pkg::TYPE_W-1:0]     memory_type,
    output logic                            accepted
);
    import mtrr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mtrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mtrr_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (func),
        .base_frame   (base_frame),
        .mask_frame   (mask_frame),
        .range_type   (range_type),
        .range_enable (range_enable),
        .page_index   (page_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .memory_type  (memory_type),
        .accepted     (accepted)
    );

    `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
    `ASSERT_CLK(a_acc_type_zero, out_valid && accepted |-> memory_type == TYPE_UC, "load type")
    `ASSERT_NEVER(a_store_full, cmd.store && sts.table_full, "store into full table")
    `ASSERT_NEVER(a_out_overwrite, cmd.out_load && sts.out_busy, "output overwritten")

endmodule
